FILE: rtl/tccw_pkg.sv
// ---------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and sizes for the text console character writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 64;

   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 6;
   localparam int COLS_REG_W = 8;
   localparam int ROWS_REG_W = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int CMD_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 2;

   localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd25;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 2'd1;

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_BACKSPACE,
      CMD_READ,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CHAR_W-1:0]        char_code;
      logic [COL_W-1:0]         read_col;
      logic [ROW_W-1:0]         read_row;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0]         cursor_col;
      logic [ROW_W-1:0]         cursor_row;
      logic [CHAR_W-1:0]        cell_char;
      logic                     scrolled;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    data;
   } csr_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRITE,
      ST_SWEEP,
      ST_SCROLL,
      ST_READ_WAIT,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/tccw_ram.sv
// ---------------------------------------------------------------------------
// tccw_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/tccw_fifo.sv
// ---------------------------------------------------------------------------
// tccw_fifo
// Small register queue used between front end, back end and result port.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic [WIDTH-1:0]  pop_data,
   output      logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tccw_front.sv
// ---------------------------------------------------------------------------
// tccw_front
// Accepts request transactions and decodes them into back end commands.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_front (
   input  wire logic                          push,
   output      logic                          full,
   input  wire logic [tccw_pkg::OP_W-1:0]     op,
   input  wire logic [tccw_pkg::CHAR_W-1:0]   char_code,
   input  wire logic [tccw_pkg::COL_W-1:0]    read_col,
   input  wire logic [tccw_pkg::ROW_W-1:0]    read_row,
   input  wire logic                          cmd_full,
   output      logic                          cmd_push,
   output      tccw_pkg::cmd_type             cmd
);

   assign full     = cmd_full;
   assign cmd_push = push && !cmd_full;

   always_comb begin
      cmd.char_code = char_code;
      cmd.read_col  = read_col;
      cmd.read_row  = read_row;
      unique case (op)
         tccw_pkg::OP_PUT: begin
            priority if (char_code == tccw_pkg::CH_CR || char_code == tccw_pkg::CH_LF) begin
               cmd.kind = tccw_pkg::CMD_NEWLINE;
            end else if (char_code == tccw_pkg::CH_BS) begin
               cmd.kind = tccw_pkg::CMD_BACKSPACE;
            end else begin
               cmd.kind = tccw_pkg::CMD_PUT;
            end
         end
         tccw_pkg::OP_READ:  cmd.kind = tccw_pkg::CMD_READ;
         tccw_pkg::OP_CLEAR: cmd.kind = tccw_pkg::CMD_CLEAR;
         default:            cmd.kind = tccw_pkg::CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tccw_back.sv
// ---------------------------------------------------------------------------
// tccw_back
// Executes commands: cursor, scroll base, row valid bits and grid memory.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_back #(
   parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tccw_pkg::csr_wr_type csr,
   input  wire logic                 cmd_valid,
   input  wire tccw_pkg::cmd_type    cmd,
   output      logic                 cmd_pop,
   input  wire logic                 rsp_full,
   output      logic                 rsp_push,
   output      tccw_pkg::rsp_type    rsp
);

   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ECW = $clog2(MAX_COLS + 1);
   localparam int ERW = $clog2(MAX_ROWS + 1);
   localparam int AW  = RW + CW;

   function automatic int unsigned limit(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   tccw_pkg::back_state_type state_ff, state_in;
   tccw_pkg::cmd_type        cmd_ff, cmd_in;

   logic [tccw_pkg::COLS_REG_W-1:0] cols_ff, cols_in;
   logic [tccw_pkg::ROWS_REG_W-1:0] rows_ff, rows_in;
   logic [CW-1:0]                   cur_col_ff, cur_col_in;
   logic [RW-1:0]                   cur_row_ff, cur_row_in;
   logic [RW-1:0]                   top_ff, top_in;
   logic [MAX_ROWS-1:0]             row_valid_ff, row_valid_in;
   logic [CW-1:0]                   sweep_ff, sweep_in;
   logic [tccw_pkg::CHAR_W-1:0]     cell_ff, cell_in;
   logic                            scrolled_ff, scrolled_in;

   logic [ECW-1:0]    eff_cols, csr_eff_cols;
   logic [ERW-1:0]    eff_rows, csr_eff_rows;
   logic [CW-1:0]     last_col;
   logic [RW-1:0]     last_row;
   logic [RW-1:0]     top_plus;
   logic [RW-1:0]     row_sel;
   logic [RW:0]       phys_sum;
   logic [RW-1:0]     phys_row;
   logic              col_at_end, row_at_end, read_hit, sweep_last;

   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   logic [tccw_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

   assign eff_cols     = ECW'(limit(int'(cols_ff), MAX_COLS));
   assign eff_rows     = ERW'(limit(int'(rows_ff), MAX_ROWS));
   assign csr_eff_cols = ECW'(limit(int'(csr.data), MAX_COLS));
   assign csr_eff_rows = ERW'(limit(int'(csr.data[tccw_pkg::ROWS_REG_W-1:0]), MAX_ROWS));
   assign last_col     = CW'(eff_cols - 1'b1);
   assign last_row     = RW'(eff_rows - 1'b1);
   assign top_plus     = (top_ff == RW'(MAX_ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign col_at_end   = (int'(cur_col_ff) + 1 >= int'(eff_cols));
   assign row_at_end   = (int'(cur_row_ff) + 1 >= int'(eff_rows));
   assign sweep_last   = (sweep_ff == CW'(MAX_COLS - 1));

   // logical row to physical row through the scroll base
   assign row_sel  = (state_ff == tccw_pkg::ST_EXEC && cmd_ff.kind == tccw_pkg::CMD_READ)
                     ? RW'(cmd_ff.read_row) : cur_row_ff;
   assign phys_sum = {1'b0, top_ff} + {1'b0, row_sel};
   assign phys_row = (phys_sum >= (RW+1)'(MAX_ROWS)) ? RW'(phys_sum - (RW+1)'(MAX_ROWS))
                                                     : RW'(phys_sum);

   assign read_hit = (int'(cmd_ff.read_col) < int'(eff_cols))
                     && (int'(cmd_ff.read_row) < int'(eff_rows))
                     && row_valid_ff[phys_row];

   assign ram_raddr = {phys_row, CW'(cmd_ff.read_col)};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      row_valid_in = row_valid_ff;
      sweep_in     = sweep_ff;
      cell_in      = cell_ff;
      scrolled_in  = scrolled_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = {phys_row, cur_col_ff};
      ram_wdata    = tccw_pkg::CH_NUL;

      unique case (state_ff)
         tccw_pkg::ST_IDLE: begin
            cell_in     = tccw_pkg::CH_NUL;
            scrolled_in = 1'b0;
            if (cmd_valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = tccw_pkg::ST_EXEC;
            end
         end
         tccw_pkg::ST_EXEC: begin
            unique case (cmd_ff.kind)
               tccw_pkg::CMD_PUT: state_in = tccw_pkg::ST_WRITE;
               tccw_pkg::CMD_BACKSPACE: begin
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                  end else if (cur_row_ff != '0) begin
                     cur_row_in = cur_row_ff - 1'b1;
                     cur_col_in = last_col;
                  end
                  state_in = tccw_pkg::ST_WRITE;
               end
               tccw_pkg::CMD_NEWLINE: begin
                  cur_col_in = '0;
                  if (!row_at_end) begin
                     cur_row_in = cur_row_ff + 1'b1;
                     state_in   = tccw_pkg::ST_DONE;
                  end else begin
                     cur_row_in  = last_row;
                     top_in      = top_plus;
                     scrolled_in = 1'b1;
                     state_in    = tccw_pkg::ST_SCROLL;
                  end
               end
               tccw_pkg::CMD_READ: begin
                  if (read_hit) begin
                     ram_re   = 1'b1;
                     state_in = tccw_pkg::ST_READ_WAIT;
                  end else begin
                     state_in = tccw_pkg::ST_DONE;
                  end
               end
               tccw_pkg::CMD_CLEAR: begin
                  row_valid_in = '0;
                  cur_col_in   = '0;
                  cur_row_in   = '0;
                  top_in       = '0;
                  state_in     = tccw_pkg::ST_DONE;
               end
               default: state_in = tccw_pkg::ST_DONE;
            endcase
         end
         tccw_pkg::ST_WRITE: begin
            if (!row_valid_ff[phys_row]) begin
               sweep_in = '0;
               state_in = tccw_pkg::ST_SWEEP;
            end else begin
               ram_we   = 1'b1;
               state_in = tccw_pkg::ST_DONE;
               if (cmd_ff.kind == tccw_pkg::CMD_PUT) begin
                  ram_wdata = cmd_ff.char_code;
                  if (!col_at_end) begin
                     cur_col_in = cur_col_ff + 1'b1;
                  end else begin
                     cur_col_in = '0;
                     if (!row_at_end) begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end else begin
                        cur_row_in  = last_row;
                        top_in      = top_plus;
                        scrolled_in = 1'b1;
                        state_in    = tccw_pkg::ST_SCROLL;
                     end
                  end
               end
            end
         end
         tccw_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = {phys_row, sweep_ff};
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_last) begin
               row_valid_in[phys_row] = 1'b1;
               state_in = tccw_pkg::ST_WRITE;
            end
         end
         tccw_pkg::ST_SCROLL: begin
            // new bottom row reads as blank until it is next written
            row_valid_in[phys_row] = 1'b0;
            state_in = tccw_pkg::ST_DONE;
         end
         tccw_pkg::ST_READ_WAIT: begin
            cell_in  = ram_rdata;
            state_in = tccw_pkg::ST_DONE;
         end
         tccw_pkg::ST_DONE: begin
            rsp_push = 1'b1;
            state_in = tccw_pkg::ST_IDLE;
         end
         default: state_in = tccw_pkg::ST_IDLE;
      endcase

      if (csr.valid) begin
         priority if (csr.index == tccw_pkg::CSR_ACTIVE_COLS) begin
            cols_in = csr.data;
            if (int'(cur_col_ff) >= int'(csr_eff_cols)) begin
               cur_col_in = CW'(csr_eff_cols - 1'b1);
            end
         end else if (csr.index == tccw_pkg::CSR_ACTIVE_ROWS) begin
            rows_in = csr.data[tccw_pkg::ROWS_REG_W-1:0];
            if (int'(cur_row_ff) >= int'(csr_eff_rows)) begin
               cur_row_in = RW'(csr_eff_rows - 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= tccw_pkg::COLS_RESET;
         rows_ff      <= tccw_pkg::ROWS_RESET;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         row_valid_ff <= '0;
         sweep_ff     <= '0;
         scrolled_ff  <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         row_valid_ff <= row_valid_in;
         sweep_ff     <= sweep_in;
         scrolled_ff  <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cell_ff <= cell_in;
   end

   tccw_ram #(
      .WIDTH (tccw_pkg::CHAR_W),
      .DEPTH (1 << AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp.cursor_col = tccw_pkg::COL_W'(cur_col_ff);
   assign rsp.cursor_row = tccw_pkg::ROW_W'(cur_row_ff);
   assign rsp.cell_char  = cell_ff;
   assign rsp.scrolled   = scrolled_ff;

   a_cursor_in_cols: assert property (@(posedge clock) disable iff (reset)
      int'(cur_col_ff) < int'(eff_cols))
      else $error("cursor column outside active columns");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result transaction pushed into full queue");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && scrolled_ff) |-> (int'(cur_row_ff) == int'(eff_rows) - 1))
      else $error("scroll reported with cursor off the last row");

   a_sweep_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tccw_pkg::ST_SWEEP && sweep_last) |=> row_valid_ff[$past(phys_row)])
      else $error("row not marked valid after sweep");

endmodule

`default_nettype wire

FILE: rtl/text_console_char_writer.sv
// ---------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console writer: character grid with cursor, wrap and scroll.
// ---------------------------------------------------------------------------
// Each transaction yields exactly one result. In the back end a put
// character or a backspace passes execute, write and done, plus scroll if
// it scrolls. A newline, a clear screen, an unused op and a read outside
// the active area or of a row not written since it was last blanked pass
// execute and done; a scrolling newline adds scroll, a read of a written
// row read wait. The grid lives in one single-port-write RAM, so the first
// write into a row after reset, a clear screen or a scroll that retired
// that row first sweeps the row to blank. No clearing pass runs after
// reset: per-row valid bits make untouched rows read as blank. Two-entry
// command and result queues decouple both ports from the back end.
`default_nettype none

module text_console_char_writer #(
   parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output      logic                              full,
   input  wire logic [tccw_pkg::OP_W-1:0]         req_op,
   input  wire logic [tccw_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tccw_pkg::COL_W-1:0]        req_read_col,
   input  wire logic [tccw_pkg::ROW_W-1:0]        req_read_row,
   output      logic                              empty,
   input  wire logic                              pop,
   output      logic [tccw_pkg::COL_W-1:0]        rsp_cursor_col,
   output      logic [tccw_pkg::ROW_W-1:0]        rsp_cursor_row,
   output      logic [tccw_pkg::CHAR_W-1:0]       rsp_cell_char,
   output      logic                              rsp_scrolled,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [tccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tccw_pkg::CSR_DATA_W-1:0]   csr_data
);

   tccw_pkg::cmd_type    front_cmd, q_cmd;
   tccw_pkg::rsp_type    back_rsp, q_rsp;
   tccw_pkg::csr_wr_type csr_wr;

   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic rsp_push, rsp_full;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   tccw_front u_front (
      .push      (push),
      .full      (full),
      .op        (req_op),
      .char_code (req_char_code),
      .read_col  (req_read_col),
      .read_row  (req_read_row),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd       (front_cmd)
   );

   tccw_fifo #(
      .WIDTH ($bits(tccw_pkg::cmd_type)),
      .DEPTH (tccw_pkg::CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (q_cmd),
      .empty     (cmd_empty)
   );

   tccw_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_wr),
      .cmd_valid (!cmd_empty),
      .cmd       (q_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   tccw_fifo #(
      .WIDTH ($bits(tccw_pkg::rsp_type)),
      .DEPTH (tccw_pkg::RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (q_rsp),
      .empty     (empty)
   );

   assign rsp_cursor_col = q_rsp.cursor_col;
   assign rsp_cursor_row = q_rsp.cursor_row;
   assign rsp_cell_char  = q_rsp.cell_char;
   assign rsp_scrolled   = q_rsp.scrolled;

endmodule

`default_nettype wire

FILE: tb/text_console_char_writer_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the text console character writer. A shadow of the
// character grid, cursor and scroll base predicts every response. Stimulus is
// a directed opener followed by randomized traffic over several grid sizes,
// with idle and stall patterns on both queue ports and one long response
// hold-off that fills the block and backs up its request side.
// ---------------------------------------------------------------------------

module text_console_char_writer_tb;

   localparam logic [tccw_pkg::OP_W-1:0]      OP_UNUSED    = 2'd3;
   localparam logic [tccw_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [tccw_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int QUIET_CYCLES = 2 * tccw_pkg::MAX_COLS_DEF + 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 400;

   class console_shadow;
      logic [tccw_pkg::CHAR_W-1:0]     cells [tccw_pkg::MAX_COLS_DEF * tccw_pkg::MAX_ROWS_DEF];
      logic [tccw_pkg::COLS_REG_W-1:0] cols_reg;
      logic [tccw_pkg::ROWS_REG_W-1:0] rows_reg;
      int                              col;
      int                              row;
      int                              top_base;
      int                              mismatches;
      tccw_pkg::rsp_type               reports_due[$];

      function new();
         foreach (cells[i]) cells[i] = tccw_pkg::CH_NUL;
         cols_reg   = tccw_pkg::COLS_RESET;
         rows_reg   = tccw_pkg::ROWS_RESET;
         col        = 0;
         row        = 0;
         top_base   = 0;
         mismatches = 0;
      endfunction

      function int cols_in_use();
         if (cols_reg == 0) return 1;
         if (cols_reg > tccw_pkg::MAX_COLS_DEF) return tccw_pkg::MAX_COLS_DEF;
         return int'(cols_reg);
      endfunction

      function int rows_in_use();
         if (rows_reg == 0) return 1;
         if (rows_reg > tccw_pkg::MAX_ROWS_DEF) return tccw_pkg::MAX_ROWS_DEF;
         return int'(rows_reg);
      endfunction

      function int slot(int c, int r);
         return ((top_base + r) % tccw_pkg::MAX_ROWS_DEF) * tccw_pkg::MAX_COLS_DEF
                + (c % tccw_pkg::MAX_COLS_DEF);
      endfunction

      function void clamp_cursor();
         if (col >= cols_in_use()) col = cols_in_use() - 1;
         if (row >= rows_in_use()) row = rows_in_use() - 1;
      endfunction

      // scroll clears the whole physical row, not only the active columns
      function bit next_row();
         row++;
         if (row < rows_in_use()) return 1'b0;
         row = rows_in_use() - 1;
         top_base = (top_base + 1) % tccw_pkg::MAX_ROWS_DEF;
         for (int c = 0; c < tccw_pkg::MAX_COLS_DEF; c++) cells[slot(c, row)] = tccw_pkg::CH_NUL;
         return 1'b1;
      endfunction

      function void write_register(logic [tccw_pkg::CSR_IDX_W-1:0] idx,
                                   logic [tccw_pkg::CSR_DATA_W-1:0] data);
         if (idx == tccw_pkg::CSR_ACTIVE_COLS) cols_reg = data;
         else if (idx == tccw_pkg::CSR_ACTIVE_ROWS) rows_reg = data[tccw_pkg::ROWS_REG_W-1:0];
         else return;
         clamp_cursor();
      endfunction

      function void take_request(logic [tccw_pkg::OP_W-1:0] op,
                                 logic [tccw_pkg::CHAR_W-1:0] ch,
                                 logic [tccw_pkg::COL_W-1:0] rc,
                                 logic [tccw_pkg::ROW_W-1:0] rr);
         tccw_pkg::rsp_type rep;
         rep = '0;
         clamp_cursor();
         case (op)
            tccw_pkg::OP_PUT: begin
               if (ch == tccw_pkg::CH_CR || ch == tccw_pkg::CH_LF) begin
                  col = 0;
                  rep.scrolled = next_row();
               end else if (ch == tccw_pkg::CH_BS) begin
                  if (col > 0) begin
                     col--;
                  end else if (row > 0) begin
                     row--;
                     col = cols_in_use() - 1;
                  end
                  cells[slot(col, row)] = tccw_pkg::CH_NUL;
               end else begin
                  cells[slot(col, row)] = ch;
                  col++;
                  if (col >= cols_in_use()) begin
                     col = 0;
                     rep.scrolled = next_row();
                  end
               end
            end
            tccw_pkg::OP_READ: begin
               if (rc < cols_in_use() && rr < rows_in_use())
                  rep.cell_char = cells[slot(rc, rr)];
            end
            tccw_pkg::OP_CLEAR: begin
               foreach (cells[i]) cells[i] = tccw_pkg::CH_NUL;
               col      = 0;
               row      = 0;
               top_base = 0;
            end
            default: ;
         endcase
         rep.cursor_col = col[tccw_pkg::COL_W-1:0];
         rep.cursor_row = row[tccw_pkg::ROW_W-1:0];
         reports_due.push_back(rep);
      endfunction

      function void check_report(logic [tccw_pkg::COL_W-1:0] c,
                                 logic [tccw_pkg::ROW_W-1:0] r,
                                 logic [tccw_pkg::CHAR_W-1:0] ch, logic scr);
         tccw_pkg::rsp_type want;
         if (reports_due.size() == 0) begin
            $error("unexpected response: cursor_col %0d cursor_row %0d", c, r);
            mismatches++;
            return;
         end
         want = reports_due.pop_front();
         if (c !== want.cursor_col) begin
            $error("cursor_col: expected %0d, actual %0d", want.cursor_col, c);
            mismatches++;
         end
         if (r !== want.cursor_row) begin
            $error("cursor_row: expected %0d, actual %0d", want.cursor_row, r);
            mismatches++;
         end
         if (ch !== want.cell_char) begin
            $error("cell_char: expected %0d, actual %0d", want.cell_char, ch);
            mismatches++;
         end
         if (scr !== want.scrolled) begin
            $error("scrolled: expected %0d, actual %0d", want.scrolled, scr);
            mismatches++;
         end
      endfunction

      function int due_count();
         return reports_due.size();
      endfunction
   endclass

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            push            = 1'b0;
   logic                            full;
   logic [tccw_pkg::OP_W-1:0]       req_op          = '0;
   logic [tccw_pkg::CHAR_W-1:0]     req_char_code   = '0;
   logic [tccw_pkg::COL_W-1:0]      req_read_col    = '0;
   logic [tccw_pkg::ROW_W-1:0]      req_read_row    = '0;
   logic                            empty;
   logic                            pop             = 1'b0;
   logic [tccw_pkg::COL_W-1:0]      rsp_cursor_col;
   logic [tccw_pkg::ROW_W-1:0]      rsp_cursor_row;
   logic [tccw_pkg::CHAR_W-1:0]     rsp_cell_char;
   logic                            rsp_scrolled;
   logic                            csr_valid       = 1'b0;
   logic                            csr_ready;
   logic [tccw_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [tccw_pkg::CSR_DATA_W-1:0] csr_data        = '0;

   int unsigned           tx_idle_pct     = 0;
   int unsigned           rx_stall_pct    = 0;
   logic                  rx_hold_pending = 1'b0;
   int                    rx_hold_left    = 0;
   int                    cycle_count     = 0;

   console_shadow sb = new();

   text_console_char_writer i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_read_col   (req_read_col),
      .req_read_row   (req_read_row),
      .empty          (empty),
      .pop            (pop),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_scrolled   (rsp_scrolled),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // transaction monitors
   always @(posedge clock) begin
      if (!reset && push && !full)
         sb.take_request(req_op, req_char_code, req_read_col, req_read_row);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_report(rsp_cursor_col, rsp_cursor_row, rsp_cell_char, rsp_scrolled);
   end

   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready)
         sb.write_register(csr_index, csr_data);
   end

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         pop          <= 1'b0;
      end else if (rx_hold_pending) begin
         rx_hold_pending <= 1'b0;
         rx_hold_left    <= HOLD_CYCLES;
         pop             <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   task automatic send_req(logic [tccw_pkg::OP_W-1:0] op, logic [tccw_pkg::CHAR_W-1:0] ch,
                           logic [tccw_pkg::COL_W-1:0] rc, logic [tccw_pkg::ROW_W-1:0] rr);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_op        <= op;
      req_char_code <= ch;
      req_read_col  <= rc;
      req_read_row  <= rr;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes stay one assignment per step
   task automatic csr_write(logic [tccw_pkg::CSR_IDX_W-1:0] idx,
                            logic [tccw_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      while (sb.due_count() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_item();
      int                          kind;
      int                          pick;
      int                          ch_pick;
      int                          rc_pick;
      int                          rr_pick;
      logic [tccw_pkg::OP_W-1:0]   op;
      logic [tccw_pkg::CHAR_W-1:0] ch;
      logic [tccw_pkg::COL_W-1:0]  rc;
      logic [tccw_pkg::ROW_W-1:0]  rr;
      pick    = $urandom_range(0, 99);
      ch_pick = $urandom_range(0, 255);
      rc_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, sb.cols_in_use() - 1);
      rr_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, sb.rows_in_use() - 1);
      ch = ch_pick[tccw_pkg::CHAR_W-1:0];
      rc = rc_pick[tccw_pkg::COL_W-1:0];
      rr = rr_pick[tccw_pkg::ROW_W-1:0];
      if (pick < 64) begin
         op   = tccw_pkg::OP_PUT;
         kind = $urandom_range(0, 9);
         if (kind == 0) ch = tccw_pkg::CH_CR;
         else if (kind == 1) ch = tccw_pkg::CH_LF;
         else if (kind <= 3) ch = tccw_pkg::CH_BS;
      end else if (pick < 94) begin
         op = tccw_pkg::OP_READ;
      end else if (pick < 97) begin
         op = OP_UNUSED;
      end else begin
         op = tccw_pkg::OP_CLEAR;
      end
      send_req(op, ch, rc, rr);
   endtask

   task automatic run_phase(logic [tccw_pkg::CSR_DATA_W-1:0] cols,
                            logic [tccw_pkg::CSR_DATA_W-1:0] rows,
                            int items, int unsigned tx_pct, int unsigned rx_pct,
                            bit squeeze);
      csr_write(tccw_pkg::CSR_ACTIVE_COLS, cols);
      csr_write(tccw_pkg::CSR_ACTIVE_ROWS, rows);
      csr_valid    <= 1'b0;
      tx_idle_pct   = tx_pct;
      rx_stall_pct <= rx_pct;
      if (squeeze) rx_hold_pending <= 1'b1;
      repeat (items) send_random_item();
      push <= 1'b0;
      wait_until_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // unmapped indexes must be ignored
      csr_write(CSR_SPARE_LO, 8'h5A);
      csr_write(CSR_SPARE_HI, 8'hFF);
      csr_valid <= 1'b0;

      send_req(tccw_pkg::OP_PUT,   8'h41,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_NUL, 7'd127, 6'd63);
      send_req(tccw_pkg::OP_PUT,   8'hFF,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   8'h1B,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'hFF,            7'd2,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd127, 6'd63);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd79,  6'd24);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd80,  6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd0,   6'd25);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_BS,  7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_CR,  7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_LF,  7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_BS,  7'd0,   6'd0);
      send_req(tccw_pkg::OP_PUT,   8'h7E,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd79,  6'd1);
      send_req(OP_UNUSED,          8'hFF,            7'd127, 6'd63);
      send_req(tccw_pkg::OP_CLEAR, 8'hFF,            7'd127, 6'd63);
      send_req(tccw_pkg::OP_PUT,   tccw_pkg::CH_BS,  7'd0,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd0,   6'd0);
      send_req(tccw_pkg::OP_READ,  8'h00,            7'd2,   6'd0);
      push <= 1'b0;
      wait_until_drained();

      run_phase(8'd4,   8'd3,   250, 0,  0,  1'b0);
      run_phase(8'd0,   8'd0,   100, 51, 0,  1'b0);
      run_phase(8'd255, 8'd255, 150, 0,  51, 1'b0);
      run_phase(8'd1,   8'd64,  150, 7,  7,  1'b0);
      run_phase(8'd128, 8'd1,   150, 0,  0,  1'b0);
      run_phase(8'd7,   8'd5,   300, 51, 0,  1'b0);
      run_phase(8'd80,  8'd25,  150, 0,  51, 1'b0);
      run_phase(8'd2,   8'd2,   200, 7,  7,  1'b0);
      run_phase(8'd16,  8'd8,   250, 0,  0,  1'b1);

      if (sb.mismatches == 0 && sb.due_count() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
